// ===== rtl/mrt_pkg.sv =====
// Types and constants shared by the memory region table modules.
package mrt_pkg;

    localparam int MAX_RESULTS = 64;
    localparam int START_W = 64;
    localparam int LEN_W = 48;
    localparam int HANDLE_W = 32;
    localparam int REFS_W = 16;
    localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        CMD_INSERT  = 3'd0,
        CMD_REMOVE  = 3'd1,
        CMD_RELEASE = 3'd2,
        CMD_FIND    = 3'd3,
        CMD_RETAIN  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_DECREMENT = 3'd4,
        ST_REMOVED   = 3'd5,
        ST_MATCH     = 3'd6,
        ST_NO_MATCH  = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        SCAN_START,
        SCAN_HANDLE,
        SCAN_FIND
    } scan_mode_t;

    typedef enum logic [2:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_SCAN,
        FSM_DRAIN,
        FSM_DECIDE
    } fsm_t;

    typedef struct packed {
        logic                valid;
        logic [START_W-1:0]  start;
        logic [LEN_W-1:0]    length;
        logic [HANDLE_W-1:0] handle;
        logic [REFS_W-1:0]   refs;
    } entry_t;

    typedef struct packed {
        logic       clear;
        logic       vld;
        scan_mode_t mode;
    } scan_ctl_t;

endpackage

// ===== rtl/mrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/mrt_scan.sv =====
// Shared compare unit that checks one table entry per cycle and keeps the best hit.
module mrt_scan #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mrt_pkg::scan_ctl_t                    ctl,
    input  logic [$clog2(TABLE_DEPTH)-1:0]        idx,
    input  mrt_pkg::entry_t                       entry,
    input  logic [mrt_pkg::START_W-1:0]           key_addr,
    input  logic [mrt_pkg::LEN_W-1:0]             key_len,
    input  logic [mrt_pkg::HANDLE_W-1:0]          key_handle,
    input  logic                                  have_prev,
    input  logic [mrt_pkg::START_W-1:0]           prev_start,
    output logic                                  found,
    output mrt_pkg::entry_t                       best,
    output logic [$clog2(TABLE_DEPTH)-1:0]        best_idx,
    output logic                                  free_found,
    output logic [$clog2(TABLE_DEPTH)-1:0]        free_idx
);

    localparam int IW = $clog2(TABLE_DEPTH);

    logic                          found_reg;
    logic                          found_next;
    logic                          free_found_reg;
    logic                          free_found_next;
    mrt_pkg::entry_t               best_reg;
    logic [IW-1:0]                 best_idx_reg;
    logic [IW-1:0]                 free_idx_reg;
    logic [mrt_pkg::START_W-1:0]   ent_len;
    logic [mrt_pkg::START_W-1:0]   qry_len;
    logic                          end_above;
    logic                          start_below;
    logic                          hit;
    logic                          take;
    logic                          take_free;

    assign ent_len = {{(mrt_pkg::START_W - mrt_pkg::LEN_W){1'b0}}, entry.length};
    assign qry_len = {{(mrt_pkg::START_W - mrt_pkg::LEN_W){1'b0}}, key_len};
    assign end_above = (entry.start > key_addr) || ((key_addr - entry.start) < ent_len);
    assign start_below = (entry.start < key_addr) || ((entry.start - key_addr) < qry_len);

    always_comb
    begin
        case (ctl.mode)
            mrt_pkg::SCAN_START:
                hit = entry.valid && (entry.start == key_addr) && !found_reg;
            mrt_pkg::SCAN_HANDLE:
                hit = entry.valid && (entry.handle == key_handle)
                      && (!found_reg || (entry.start < best_reg.start));
            mrt_pkg::SCAN_FIND:
                hit = entry.valid && end_above && start_below
                      && (!have_prev || (entry.start > prev_start))
                      && (!found_reg || (entry.start < best_reg.start));
            default:
                hit = 1'b0;
        endcase
    end

    assign take = ctl.vld && hit;
    assign take_free = ctl.vld && !entry.valid && !free_found_reg;
    assign found_next = ctl.clear ? 1'b0 : (found_reg || take);
    assign free_found_next = ctl.clear ? 1'b0 : (free_found_reg || take_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !ctl.clear)
        begin
            best_reg <= entry;
            best_idx_reg <= idx;
        end
        if (take_free && !ctl.clear)
        begin
            free_idx_reg <= idx;
        end
    end

    assign found = found_reg;
    assign best = best_reg;
    assign best_idx = best_idx_reg;
    assign free_found = free_found_reg;
    assign free_idx = free_idx_reg;

endmodule

// ===== rtl/memory_region_table_unit.sv =====
// Top level of the memory region table: command sequencer, table RAM and result register.
// One command is taken at a time; each table scan reads one entry per cycle from the single
// RAM read port. Insert, remove, retain and release each run one scan, and a find returning
// n regions runs n + 1 scans; a decision waits while the result side holds off a beat.
// After reset every table entry is cleared before the first command is taken.
module memory_region_table_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [143:0] s_axis_tdata,   // address, length, handle
    input  logic [2:0]   s_axis_tuser,   // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata,   // region_start, region_length, region_handle, refs
    output logic [2:0]   m_axis_tuser,   // status
    output logic         m_axis_tlast
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH) + 1;
    localparam int EW = $bits(mrt_pkg::entry_t);

    mrt_pkg::fsm_t                   state_reg;
    mrt_pkg::fsm_t                   state_next;
    logic [CW-1:0]                   cnt_reg;
    logic [CW-1:0]                   cnt_next;
    logic                            rd_pend_reg;
    logic [IW-1:0]                   rd_idx_reg;
    logic [2:0]                      cmd_reg;
    logic [mrt_pkg::START_W-1:0]     addr_reg;
    logic [mrt_pkg::LEN_W-1:0]       len_reg;
    logic [mrt_pkg::HANDLE_W-1:0]    hnd_reg;
    logic                            pend_vld_reg;
    logic                            pend_vld_next;
    mrt_pkg::entry_t                 pend_reg;
    logic [mrt_pkg::RES_CNT_W-1:0]   res_cnt_reg;
    logic [mrt_pkg::RES_CNT_W-1:0]   res_cnt_next;
    logic                            m_valid_reg;
    logic                            m_valid_next;
    mrt_pkg::status_t                out_status_reg;
    mrt_pkg::entry_t                 out_entry_reg;
    logic                            out_last_reg;

    logic                            accept;
    logic                            out_free;
    logic                            restart;
    logic                            emit;
    mrt_pkg::status_t                emit_status;
    mrt_pkg::entry_t                 emit_entry;
    logic                            emit_last;
    logic                            load_pend;
    logic                            ram_we;
    logic [IW-1:0]                   ram_waddr;
    mrt_pkg::entry_t                 ram_wdata;
    logic [EW-1:0]                   ram_rdata;
    mrt_pkg::scan_ctl_t              scan_ctl;
    mrt_pkg::scan_mode_t             mode;
    logic                            found;
    mrt_pkg::entry_t                 best;
    logic [IW-1:0]                   best_idx;
    logic                            free_found;
    logic [IW-1:0]                   free_idx;
    logic [mrt_pkg::REFS_W-1:0]      refs_dec;
    logic [mrt_pkg::REFS_W-1:0]      refs_inc;

    assign s_axis_tready = (state_reg == mrt_pkg::FSM_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        case (cmd_reg)
            mrt_pkg::CMD_RELEASE, mrt_pkg::CMD_RETAIN: mode = mrt_pkg::SCAN_HANDLE;
            mrt_pkg::CMD_FIND:                         mode = mrt_pkg::SCAN_FIND;
            default:                                   mode = mrt_pkg::SCAN_START;
        endcase
    end

    mrt_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cnt_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    assign scan_ctl.clear = accept || restart;
    assign scan_ctl.vld = rd_pend_reg;
    assign scan_ctl.mode = mode;

    mrt_scan #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .idx        (rd_idx_reg),
        .entry      (mrt_pkg::entry_t'(ram_rdata)),
        .key_addr   (addr_reg),
        .key_len    (len_reg),
        .key_handle (hnd_reg),
        .have_prev  (pend_vld_reg),
        .prev_start (pend_reg.start),
        .found      (found),
        .best       (best),
        .best_idx   (best_idx),
        .free_found (free_found),
        .free_idx   (free_idx)
    );

    assign refs_dec = (best.refs != '0) ? best.refs - 1'b1 : '0;
    assign refs_inc = (best.refs != '1) ? best.refs + 1'b1 : best.refs;

    always_comb
    begin
        emit = 1'b0;
        emit_status = mrt_pkg::ST_NOT_FOUND;
        emit_entry = '0;
        emit_last = 1'b1;
        ram_we = 1'b0;
        ram_waddr = best_idx;
        ram_wdata = best;
        restart = 1'b0;
        load_pend = 1'b0;
        pend_vld_next = pend_vld_reg;
        res_cnt_next = res_cnt_reg;
        if (state_reg == mrt_pkg::FSM_CLEAR)
        begin
            ram_we = 1'b1;
            ram_waddr = cnt_reg[IW-1:0];
            ram_wdata = '0;
        end
        if (accept)
        begin
            pend_vld_next = 1'b0;
            res_cnt_next = '0;
        end
        if ((state_reg == mrt_pkg::FSM_DECIDE) && out_free)
        begin
            case (cmd_reg)
                mrt_pkg::CMD_INSERT:
                begin
                    emit = 1'b1;
                    if (found)
                    begin
                        emit_status = mrt_pkg::ST_DUPLICATE;
                        emit_entry = best;
                    end
                    else if (!free_found)
                    begin
                        emit_status = mrt_pkg::ST_FULL;
                    end
                    else
                    begin
                        emit_status = mrt_pkg::ST_OK;
                        emit_entry = {1'b1, addr_reg, len_reg, hnd_reg,
                                      mrt_pkg::REFS_W'(1)};
                        ram_we = 1'b1;
                        ram_waddr = free_idx;
                        ram_wdata = emit_entry;
                    end
                end
                mrt_pkg::CMD_REMOVE:
                begin
                    emit = 1'b1;
                    if (found)
                    begin
                        emit_status = mrt_pkg::ST_REMOVED;
                        emit_entry = best;
                        ram_we = 1'b1;
                        ram_wdata.valid = 1'b0;
                    end
                end
                mrt_pkg::CMD_RETAIN:
                begin
                    emit = 1'b1;
                    if (found)
                    begin
                        emit_status = mrt_pkg::ST_OK;
                        emit_entry = best;
                        emit_entry.refs = refs_inc;
                        ram_we = 1'b1;
                        ram_wdata.refs = refs_inc;
                    end
                end
                mrt_pkg::CMD_RELEASE:
                begin
                    emit = 1'b1;
                    if (found)
                    begin
                        emit_entry = best;
                        emit_entry.refs = refs_dec;
                        ram_we = 1'b1;
                        ram_wdata.refs = refs_dec;
                        if (refs_dec == '0)
                        begin
                            emit_status = mrt_pkg::ST_REMOVED;
                            ram_wdata.valid = 1'b0;
                        end
                        else
                        begin
                            emit_status = mrt_pkg::ST_DECREMENT;
                        end
                    end
                end
                mrt_pkg::CMD_FIND:
                begin
                    if (!pend_vld_reg)
                    begin
                        if (found)
                        begin
                            load_pend = 1'b1;
                            pend_vld_next = 1'b1;
                            res_cnt_next = mrt_pkg::RES_CNT_W'(1);
                            restart = 1'b1;
                        end
                        else
                        begin
                            emit = 1'b1;
                            emit_status = mrt_pkg::ST_NO_MATCH;
                        end
                    end
                    else
                    begin
                        emit = 1'b1;
                        emit_status = mrt_pkg::ST_MATCH;
                        emit_entry = pend_reg;
                        emit_last = !found
                                    || (res_cnt_reg == mrt_pkg::RES_CNT_W'(mrt_pkg::MAX_RESULTS));
                        if (!emit_last)
                        begin
                            load_pend = 1'b1;
                            res_cnt_next = res_cnt_reg + 1'b1;
                            restart = 1'b1;
                        end
                    end
                end
                default:
                begin
                    emit = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            mrt_pkg::FSM_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(TABLE_DEPTH - 1))
                begin
                    state_next = mrt_pkg::FSM_IDLE;
                    cnt_next = '0;
                end
            end
            mrt_pkg::FSM_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    state_next = mrt_pkg::FSM_SCAN;
                end
            end
            mrt_pkg::FSM_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(TABLE_DEPTH - 1))
                begin
                    state_next = mrt_pkg::FSM_DRAIN;
                end
            end
            mrt_pkg::FSM_DRAIN:
            begin
                cnt_next = '0;
                state_next = mrt_pkg::FSM_DECIDE;
            end
            mrt_pkg::FSM_DECIDE:
            begin
                cnt_next = '0;
                if (restart)
                begin
                    state_next = mrt_pkg::FSM_SCAN;
                end
                else if (emit)
                begin
                    state_next = mrt_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = mrt_pkg::FSM_IDLE;
            end
        endcase
    end

    assign m_valid_next = emit || (m_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mrt_pkg::FSM_CLEAR;
            cnt_reg <= '0;
            rd_pend_reg <= 1'b0;
            pend_vld_reg <= 1'b0;
            res_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            rd_pend_reg <= (state_reg == mrt_pkg::FSM_SCAN);
            pend_vld_reg <= pend_vld_next;
            res_cnt_reg <= res_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= cnt_reg[IW-1:0];
        if (accept)
        begin
            cmd_reg <= s_axis_tuser;
            addr_reg <= s_axis_tdata[63:0];
            len_reg <= s_axis_tdata[111:64];
            hnd_reg <= s_axis_tdata[143:112];
        end
        if (load_pend)
        begin
            pend_reg <= best;
        end
        if (emit)
        begin
            out_status_reg <= emit_status;
            out_entry_reg <= emit_entry;
            out_last_reg <= emit_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser = out_status_reg;
    assign m_axis_tlast = out_last_reg;
    assign m_axis_tdata = {out_entry_reg.refs, out_entry_reg.handle,
                           out_entry_reg.length, out_entry_reg.start};

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mrt_pkg::FSM_SCAN) |-> !ram_we)
        else $error("Table written during a scan.");

    a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !rd_pend_reg)
        else $error("Read data pending while idle.");

    a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg <= mrt_pkg::RES_CNT_W'(mrt_pkg::MAX_RESULTS))
        else $error("Find result count out of range.");

    a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("Result loaded over an untaken beat.");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the memory region table unit.
`timescale 1ns / 100ps

module tb_top;

    localparam int DEPTH = 64;

    typedef struct {
        logic [2:0]                   cmd;
        logic [mrt_pkg::START_W-1:0]  addr;
        logic [mrt_pkg::LEN_W-1:0]    len;
        logic [mrt_pkg::HANDLE_W-1:0] hnd;
    } cmd_item_t;

    typedef struct {
        logic [2:0]                   status;
        logic [mrt_pkg::START_W-1:0]  start;
        logic [mrt_pkg::LEN_W-1:0]    len;
        logic [mrt_pkg::HANDLE_W-1:0] hnd;
        logic [mrt_pkg::REFS_W-1:0]   refs;
        logic                         last;
    } region_rsp_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata = '0;
    logic [2:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [159:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         s_axis_tready_q = 1'b0;

    cmd_item_t   pending_cmds[$];
    region_rsp_t expected_rsps[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          error_count = 0;
    int          accepted_cmds = 0;
    int          seen_rsps = 0;

    logic                         tbl_valid[DEPTH];
    logic [mrt_pkg::START_W-1:0]  tbl_start[DEPTH];
    logic [mrt_pkg::LEN_W-1:0]    tbl_len[DEPTH];
    logic [mrt_pkg::HANDLE_W-1:0] tbl_hnd[DEPTH];
    logic [mrt_pkg::REFS_W-1:0]   tbl_refs[DEPTH];

    memory_region_table_unit #(.TABLE_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #10 clk = ~clk;

    function automatic void add_rsp(region_rsp_t r);
        expected_rsps.insert(expected_rsps.size(), r);
    endfunction

    function automatic void add_cmd(cmd_item_t c);
        pending_cmds.insert(pending_cmds.size(), c);
    endfunction

    function automatic region_rsp_t make_rsp(logic [2:0] st, int idx,
                                             logic [mrt_pkg::REFS_W-1:0] refs);
        region_rsp_t r;
        r.status = st;
        r.refs = refs;
        r.last = 1'b1;
        if (idx >= 0) begin
            r.start = tbl_start[idx];
            r.len = tbl_len[idx];
            r.hnd = tbl_hnd[idx];
        end
        else begin
            r.start = '0;
            r.len = '0;
            r.hnd = '0;
        end
        return r;
    endfunction

    function automatic logic region_overlaps(int i, logic [63:0] qs, logic [47:0] ql);
        logic [64:0] r_end;
        logic [64:0] q_end;
        r_end = {1'b0, tbl_start[i]} + {17'd0, tbl_len[i]};
        q_end = {1'b0, qs} + {17'd0, ql};
        return (r_end > {1'b0, qs}) && ({1'b0, tbl_start[i]} < q_end);
    endfunction

    task automatic predict_table(input cmd_item_t c);
        int idx;
        int n;
        int prev;
        int best;
        idx = -1;
        case (c.cmd)
            mrt_pkg::CMD_INSERT, mrt_pkg::CMD_REMOVE:
            begin
                for (int i = 0; i < DEPTH; i++)
                    if (idx < 0 && tbl_valid[i] && tbl_start[i] == c.addr) idx = i;
                if (c.cmd == mrt_pkg::CMD_REMOVE) begin
                    if (idx < 0) add_rsp(make_rsp(mrt_pkg::ST_NOT_FOUND, -1, 16'd0));
                    else begin
                        add_rsp(make_rsp(mrt_pkg::ST_REMOVED, idx, tbl_refs[idx]));
                        tbl_valid[idx] = 1'b0;
                    end
                end
                else if (idx >= 0) begin
                    add_rsp(make_rsp(mrt_pkg::ST_DUPLICATE, idx, tbl_refs[idx]));
                end
                else begin
                    for (int i = 0; i < DEPTH; i++)
                        if (idx < 0 && !tbl_valid[i]) idx = i;
                    if (idx < 0) add_rsp(make_rsp(mrt_pkg::ST_FULL, -1, 16'd0));
                    else begin
                        tbl_valid[idx] = 1'b1;
                        tbl_start[idx] = c.addr;
                        tbl_len[idx] = c.len;
                        tbl_hnd[idx] = c.hnd;
                        tbl_refs[idx] = 16'd1;
                        add_rsp(make_rsp(mrt_pkg::ST_OK, idx, 16'd1));
                    end
                end
            end
            mrt_pkg::CMD_RELEASE, mrt_pkg::CMD_RETAIN:
            begin
                for (int i = 0; i < DEPTH; i++)
                    if (tbl_valid[i] && tbl_hnd[i] == c.hnd &&
                        (idx < 0 || tbl_start[i] < tbl_start[idx])) idx = i;
                if (idx < 0) add_rsp(make_rsp(mrt_pkg::ST_NOT_FOUND, -1, 16'd0));
                else if (c.cmd == mrt_pkg::CMD_RETAIN) begin
                    if (tbl_refs[idx] != 16'hFFFF) tbl_refs[idx]++;
                    add_rsp(make_rsp(mrt_pkg::ST_OK, idx, tbl_refs[idx]));
                end
                else begin
                    if (tbl_refs[idx] != 0) tbl_refs[idx]--;
                    if (tbl_refs[idx] == 0) begin
                        add_rsp(make_rsp(mrt_pkg::ST_REMOVED, idx, 16'd0));
                        tbl_valid[idx] = 1'b0;
                    end
                    else add_rsp(make_rsp(mrt_pkg::ST_DECREMENT, idx, tbl_refs[idx]));
                end
            end
            mrt_pkg::CMD_FIND:
            begin
                n = 0;
                prev = -1;
                best = 0;
                while (n < mrt_pkg::MAX_RESULTS && best >= 0) begin
                    best = -1;
                    for (int i = 0; i < DEPTH; i++) begin
                        if (tbl_valid[i] && region_overlaps(i, c.addr, c.len) &&
                            !(prev >= 0 && tbl_start[i] <= tbl_start[prev]) &&
                            (best < 0 || tbl_start[i] < tbl_start[best])) best = i;
                    end
                    if (best >= 0) begin
                        add_rsp(make_rsp(mrt_pkg::ST_MATCH, best, tbl_refs[best]));
                        expected_rsps[$].last = 1'b0;
                        n++;
                        prev = best;
                    end
                end
                if (n == 0) add_rsp(make_rsp(mrt_pkg::ST_NO_MATCH, -1, 16'd0));
                else expected_rsps[$].last = 1'b1;
            end
            default:
                add_rsp(make_rsp(mrt_pkg::ST_NOT_FOUND, -1, 16'd0));
        endcase
    endtask

    always @(negedge clk) begin
        if (rst_n) begin
            if (!s_axis_tvalid || s_axis_tready_q) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cmd_item_t c;
                    c = pending_cmds.pop_front();
                    s_axis_tdata <= {c.hnd, c.len, c.addr};
                    s_axis_tuser <= c.cmd;
                    s_axis_tvalid <= 1'b1;
                end
                else s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // The driver needs to know whether the beat on the bus went through at the last edge.
    always @(posedge clk) begin
        cmd_item_t c;
        s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready) begin
            c.addr = s_axis_tdata[63:0];
            c.len = s_axis_tdata[111:64];
            c.hnd = s_axis_tdata[143:112];
            c.cmd = s_axis_tuser;
            predict_table(c);
            accepted_cmds++;
        end
    end

    always @(posedge clk) begin
        region_rsp_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_rsps++;
            if (expected_rsps.size() == 0) begin
                $error("unexpected beat: status %0d", m_axis_tuser);
                error_count++;
            end
            else begin
                e = expected_rsps.pop_front();
                if (m_axis_tuser !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[63:0] !== e.start) begin
                    $error("region_start: expected %h, got %h", e.start, m_axis_tdata[63:0]);
                    error_count++;
                end
                if (m_axis_tdata[111:64] !== e.len) begin
                    $error("region_length: expected %h, got %h", e.len, m_axis_tdata[111:64]);
                    error_count++;
                end
                if (m_axis_tdata[143:112] !== e.hnd) begin
                    $error("region_handle: expected %h, got %h", e.hnd, m_axis_tdata[143:112]);
                    error_count++;
                end
                if (m_axis_tdata[159:144] !== e.refs) begin
                    $error("region_refs: expected %0d, got %0d", e.refs, m_axis_tdata[159:144]);
                    error_count++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    function automatic cmd_item_t mk(logic [2:0] c, logic [63:0] a, logic [47:0] l,
                                     logic [31:0] h);
        cmd_item_t r;
        r.cmd = c;
        r.addr = a;
        r.len = l;
        r.hnd = h;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_axis_tvalid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (3 * DEPTH) @(posedge clk);
    endtask

    // Commands mostly hit a small pool of starts and handles so that the table fills and
    // handle searches succeed; the rest is random over the full field ranges.
    task automatic queue_random(int count);
        logic [63:0] a;
        logic [47:0] l;
        logic [31:0] h;
        logic [2:0]  c;
        int          k;
        for (int j = 0; j < count; j++) begin
            k = $urandom_range(99);
            if (k < 40) c = mrt_pkg::CMD_INSERT;
            else if (k < 50) c = mrt_pkg::CMD_REMOVE;
            else if (k < 62) c = mrt_pkg::CMD_RELEASE;
            else if (k < 72) c = mrt_pkg::CMD_RETAIN;
            else if (k < 95) c = mrt_pkg::CMD_FIND;
            else c = 3'($urandom_range(7));
            if ($urandom_range(9) < 8) begin
                a = 64'h1000 * $urandom_range(80);
                l = 48'($urandom_range(16'h6000));
                h = 32'($urandom_range(15));
            end
            else begin
                a = rand64();
                l = 48'(rand64());
                h = $urandom();
            end
            if (c == mrt_pkg::CMD_FIND && $urandom_range(9) == 0) l = 48'hFFFF_FFFF_FFFF;
            add_cmd(mk(c, a, l, h));
        end
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_cmd(mk(mrt_pkg::CMD_FIND, 64'd0, 48'hFFFF_FFFF_FFFF, 32'd0));
        add_cmd(mk(mrt_pkg::CMD_INSERT, 64'd0, 48'd0, 32'd0));
        add_cmd(mk(mrt_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                   32'hFFFF_FFFF));
        add_cmd(mk(mrt_pkg::CMD_INSERT, 64'h100, 48'h100, 32'd7));
        add_cmd(mk(mrt_pkg::CMD_INSERT, 64'h100, 48'h5, 32'd9));
        add_cmd(mk(mrt_pkg::CMD_INSERT, 64'h180, 48'h10, 32'd7));
        add_cmd(mk(mrt_pkg::CMD_FIND, 64'h150, 48'd0, 32'd0));
        add_cmd(mk(mrt_pkg::CMD_FIND, 64'h100, 48'd0, 32'd0));
        add_cmd(mk(mrt_pkg::CMD_FIND, 64'h200, 48'h10, 32'd0));
        add_cmd(mk(mrt_pkg::CMD_FIND, 64'hFFFF_FFFF_FFFF_FFF0, 48'h20, 32'd0));
        add_cmd(mk(mrt_pkg::CMD_RETAIN, 64'd0, 48'd0, 32'd7));
        add_cmd(mk(mrt_pkg::CMD_RELEASE, 64'd0, 48'd0, 32'd7));
        add_cmd(mk(mrt_pkg::CMD_RELEASE, 64'd0, 48'd0, 32'd7));
        add_cmd(mk(mrt_pkg::CMD_RELEASE, 64'd0, 48'd0, 32'd7));
        add_cmd(mk(mrt_pkg::CMD_RELEASE, 64'd0, 48'd0, 32'd1234));
        add_cmd(mk(mrt_pkg::CMD_RETAIN, 64'd0, 48'd0, 32'hFFFF_FFFF));
        add_cmd(mk(mrt_pkg::CMD_REMOVE, 64'h100, 48'd0, 32'd0));
        add_cmd(mk(mrt_pkg::CMD_REMOVE, 64'h5555, 48'd0, 32'd0));
        add_cmd(mk(3'd5, rand64(), 48'h1, 32'd1));
        add_cmd(mk(3'd6, 64'd0, 48'd0, 32'd0));
        add_cmd(mk(3'd7, 64'd0, 48'd0, 32'd0));
        for (int i = 0; i < 66; i++)
            add_cmd(mk(mrt_pkg::CMD_INSERT, 64'h10_0000 + 64'(i) * 64'h10, 48'h10, 32'd3));
        add_cmd(mk(mrt_pkg::CMD_FIND, 64'd0, 48'hFFFF_FFFF_FFFF, 32'd0));
        for (int i = 0; i < 66; i++)
            add_cmd(mk(mrt_pkg::CMD_RELEASE, 64'd0, 48'd0, 32'd3));

        send_idle_pct = 36;
        recv_idle_pct = 72;
        queue_random(82);
        wait_drained();
        send_idle_pct = 72;
        recv_idle_pct = 36;
        queue_random(82);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(82);
        wait_drained();

        $display("Run covered %0d commands and %0d result beats across three stall mixes.",
                 accepted_cmds, seen_rsps);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #400ms;
        $display("Timeout after %0d commands and %0d result beats.", accepted_cmds, seen_rsps);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/mrt_pkg.sv
rtl/mrt_ram.sv
rtl/mrt_scan.sv
rtl/memory_region_table_unit.sv
bench/tb_top.sv
